// File: sv/esm_pkg.sv
package esm_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int CORDIC_STEPS   = 31;
    localparam int STEP_W         = 5;
    // CORDIC datapath width: Q30 plus gain headroom and sign
    localparam int XW             = 34;
    // trig value width: range [-2^F, 2^F]
    localparam int TW             = TRIG_FRAC_BITS + 2;
    // bracket sum width
    localparam int SW             = TW + 1;
    localparam int CS             = 30 - TRIG_FRAC_BITS;
    localparam int ES             = TRIG_FRAC_BITS - 8;

    localparam logic signed [XW-1:0] CORDIC_ONE = XW'(652032874);

    typedef struct packed {
        logic                  valid;
        logic [2:0][XW-1:0]    x;
        logic [2:0][XW-1:0]    y;
        logic [2:0][XW-1:0]    z;
        logic [2:0]            neg;
        logic [2:0][31:0]      pos;
        logic [2:0][15:0]      scale;
    } cordic_t;

    typedef struct packed {
        logic [8:0][31:0] m;
        logic [2:0][31:0] t;
    } result_t;

    // arctangent of 2^-idx as a 32-bit phase
    function automatic logic signed [XW-1:0] atan_phase(input logic [STEP_W-1:0] idx);
        logic signed [XW-1:0] r;
        begin
            unique case (idx)
                5'd0:    r = XW'(536870912);
                5'd1:    r = XW'(316933405);
                5'd2:    r = XW'(167458907);
                5'd3:    r = XW'(85004756);
                5'd4:    r = XW'(42667331);
                5'd5:    r = XW'(21354465);
                5'd6:    r = XW'(10679838);
                5'd7:    r = XW'(5340245);
                5'd8:    r = XW'(2670163);
                5'd9:    r = XW'(1335087);
                5'd10:   r = XW'(667544);
                5'd11:   r = XW'(333772);
                5'd12:   r = XW'(166886);
                5'd13:   r = XW'(83443);
                5'd14:   r = XW'(41721);
                5'd15:   r = XW'(20860);
                5'd16:   r = XW'(10430);
                5'd17:   r = XW'(5215);
                5'd18:   r = XW'(2607);
                5'd19:   r = XW'(1303);
                5'd20:   r = XW'(651);
                5'd21:   r = XW'(325);
                5'd22:   r = XW'(162);
                5'd23:   r = XW'(81);
                5'd24:   r = XW'(40);
                5'd25:   r = XW'(20);
                5'd26:   r = XW'(10);
                5'd27:   r = XW'(5);
                5'd28:   r = XW'(2);
                5'd29:   r = XW'(1);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // round Q30 to trig precision and clamp to +/- one
    function automatic logic signed [TW-1:0] trig_round(input logic signed [XW-1:0] v);
        logic signed [XW:0] w;
        logic signed [XW:0] r;
        logic signed [XW:0] one;
        begin
            w   = {v[XW-1], v};
            one = (XW+1)'(1) <<< TRIG_FRAC_BITS;
            if (CS == 0)
            begin
                r = w;
            end
            else
            begin
                r = (w + ((XW+1)'(1) <<< (CS - 1))) >>> CS;
            end
            if (r > one)
            begin
                r = one;
            end
            else if (r < -one)
            begin
                r = -one;
            end
            return TW'(r);
        end
    endfunction

    // product of two trig values, rounded back to trig precision
    function automatic logic signed [TW-1:0] prod_round(input logic signed [TW-1:0] a,
                                                         input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] p;
        logic signed [2*TW:0]   r;
        begin
            p = a * b;
            r = ({p[2*TW-1], p} + ((2*TW+1)'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
            return TW'(r);
        end
    endfunction

    // bracket times Q8.8 scale, rounded to Q16.16 and saturated
    function automatic logic [31:0] entry_sat(input logic signed [SW-1:0] term,
                                              input logic signed [15:0] scale);
        logic signed [SW+15:0] p;
        logic signed [SW+16:0] r;
        begin
            p = term * scale;
            if (ES == 0)
            begin
                r = {p[SW+15], p};
            end
            else
            begin
                r = ($signed({p[SW+15], p}) + ((SW+17)'(1) <<< (ES - 1))) >>> ES;
            end
            if (r > (SW+17)'(64'sd2147483647))
            begin
                r = (SW+17)'(64'sd2147483647);
            end
            else if (r < -(SW+17)'(64'sd2147483648))
            begin
                r = -(SW+17)'(64'sd2147483648);
            end
            return r[31:0];
        end
    endfunction

endpackage

// File: sv/esm_if.sv
interface esm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;

    modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                    scale_x, scale_y, scale_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                    scale_x, scale_y, scale_z, output ready);
endinterface

interface esm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    tx, ty, tz, input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    tx, ty, tz, output ready);
endinterface

// File: sv/esm_cordic_cell.sv
module esm_cordic_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [esm_pkg::STEP_W-1:0]   step,
    input  esm_pkg::cordic_t             st_in,
    output esm_pkg::cordic_t             st_out
);

    esm_pkg::cordic_t st_reg;
    esm_pkg::cordic_t st_next;

    // one micro-rotation on each of the three angle lanes
    always_comb
    begin
        logic signed [esm_pkg::XW-1:0] x;
        logic signed [esm_pkg::XW-1:0] y;
        logic signed [esm_pkg::XW-1:0] z;
        logic signed [esm_pkg::XW-1:0] dx;
        logic signed [esm_pkg::XW-1:0] dy;
        logic signed [esm_pkg::XW-1:0] a;
        st_next = st_in;
        a       = esm_pkg::atan_phase(step);
        for (int k = 0; k < 3; k++)
        begin
            x  = $signed(st_in.x[k]);
            y  = $signed(st_in.y[k]);
            z  = $signed(st_in.z[k]);
            dx = y >>> step;
            dy = x >>> step;
            if (!z[esm_pkg::XW-1])
            begin
                st_next.x[k] = x - dx;
                st_next.y[k] = y + dy;
                st_next.z[k] = z - a;
            end
            else
            begin
                st_next.x[k] = x + dx;
                st_next.y[k] = y - dy;
                st_next.z[k] = z + a;
            end
        end
    end

    // advance when the pipeline moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

// File: sv/esm_matrix_math.sv
module esm_matrix_math (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  esm_pkg::cordic_t  st,
    output logic              res_valid,
    output esm_pkg::result_t  res
);

    localparam int TW = esm_pkg::TW;
    localparam int SW = esm_pkg::SW;

    // trig stage: lane 0 is angle_y, lane 1 angle_x, lane 2 angle_z
    logic                        tv_reg, tv_next;
    logic [2:0][TW-1:0]          sn_reg, sn_next;
    logic [2:0][TW-1:0]          cs_reg, cs_next;
    logic [2:0][31:0]            tpos_reg;
    logic [2:0][15:0]            tscl_reg;

    always_comb
    begin
        logic signed [TW-1:0] s;
        logic signed [TW-1:0] c;
        tv_next = st.valid;
        for (int k = 0; k < 3; k++)
        begin
            c = esm_pkg::trig_round($signed(st.x[k]));
            s = esm_pkg::trig_round($signed(st.y[k]));
            cs_next[k] = st.neg[k] ? -c : c;
            sn_next[k] = st.neg[k] ? -s : s;
        end
    end

    // pairwise products
    logic                        av_reg;
    logic signed [TW-1:0]        c1c3_reg, s1s2_reg, c2s3_reg, c1s2_reg, c3s1_reg;
    logic signed [TW-1:0]        c2c3_reg, s1s3_reg, c2s1_reg, c1c2_reg, c1s3_reg;
    logic signed [TW-1:0]        as2_reg, as3_reg;
    logic [2:0][31:0]            apos_reg;
    logic [2:0][15:0]            ascl_reg;

    logic signed [TW-1:0] s1, c1, s2, c2, s3, c3;
    assign s1 = $signed(sn_reg[0]);
    assign c1 = $signed(cs_reg[0]);
    assign s2 = $signed(sn_reg[1]);
    assign c2 = $signed(cs_reg[1]);
    assign s3 = $signed(sn_reg[2]);
    assign c3 = $signed(cs_reg[2]);

    // triple products and bracket sums
    logic                        bv_reg;
    logic [8:0][SW-1:0]          term_reg, term_next;
    logic [2:0][31:0]            bpos_reg;
    logic [2:0][15:0]            bscl_reg;

    always_comb
    begin
        term_next[0] = SW'(c1c3_reg) + SW'(esm_pkg::prod_round(s1s2_reg, as3_reg));
        term_next[1] = SW'(c2s3_reg);
        term_next[2] = SW'(esm_pkg::prod_round(c1s2_reg, as3_reg)) - SW'(c3s1_reg);
        term_next[3] = SW'(esm_pkg::prod_round(c3s1_reg, as2_reg)) - SW'(c1s3_reg);
        term_next[4] = SW'(c2c3_reg);
        term_next[5] = SW'(esm_pkg::prod_round(c1c3_reg, as2_reg)) + SW'(s1s3_reg);
        term_next[6] = SW'(c2s1_reg);
        term_next[7] = -SW'(as2_reg);
        term_next[8] = SW'(c1c2_reg);
    end

    // scale, round and saturate into the output register
    logic                        ov_reg;
    esm_pkg::result_t            res_reg, res_next;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            res_next.m[k] = esm_pkg::entry_sat($signed(term_reg[k]),
                                               $signed(bscl_reg[k / 3]));
        end
        res_next.t = bpos_reg;
    end

    // hold valid bits under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= 1'b0;
            av_reg <= 1'b0;
            bv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            tv_reg <= tv_next;
            av_reg <= tv_reg;
            bv_reg <= av_reg;
            ov_reg <= bv_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_reg   <= sn_next;
            cs_reg   <= cs_next;
            tpos_reg <= st.pos;
            tscl_reg <= st.scale;

            c1c3_reg <= esm_pkg::prod_round(c1, c3);
            s1s2_reg <= esm_pkg::prod_round(s1, s2);
            c2s3_reg <= esm_pkg::prod_round(c2, s3);
            c1s2_reg <= esm_pkg::prod_round(c1, s2);
            c3s1_reg <= esm_pkg::prod_round(c3, s1);
            c2c3_reg <= esm_pkg::prod_round(c2, c3);
            s1s3_reg <= esm_pkg::prod_round(s1, s3);
            c2s1_reg <= esm_pkg::prod_round(c2, s1);
            c1c2_reg <= esm_pkg::prod_round(c1, c2);
            c1s3_reg <= esm_pkg::prod_round(c1, s3);
            as2_reg  <= s2;
            as3_reg  <= s3;
            apos_reg <= tpos_reg;
            ascl_reg <= tscl_reg;

            term_reg <= term_next;
            bpos_reg <= apos_reg;
            bscl_reg <= ascl_reg;

            res_reg  <= res_next;
        end
    end

    assign res_valid = ov_reg;
    assign res       = res_reg;

endmodule

// File: sv/euler_scale_transform_matrix_top.sv
// Scale-rotation-translation matrix engine, Y-X-Z Euler order.
// Channel obj carries one object per beat: position (Q16.16), three binary
// angles and three Q8.8 axis scales. Channel mat returns one beat with the
// nine scaled rotation entries (Q16.16, saturated) and the copied position.
// An object whose x scale is zero or negative is taken and yields no beat.
// Throughput: one object per cycle, sustained while mat is ready.
// From accept to mat.valid a beat passes one input stage, a row of 31
// CORDIC cells (one micro-rotation per cell, all three angles side by side),
// then trig rounding, pairwise products, triple products with sums, and the
// scaling stage that loads the output register.
// The whole row advances together; when mat is stalled with a beat pending,
// obj.ready drops and every stage holds, so nothing is lost or repeated.
// Reset clears all valid bits; the block is ready right after reset.
module euler_scale_transform_matrix_top (
    input  logic       clk,
    input  logic       rst_n,
    esm_in_if.sink     obj,
    esm_out_if.source  mat
);

    localparam int N  = esm_pkg::CORDIC_STEPS;
    localparam int AB = esm_pkg::ANGLE_BITS;
    localparam int XW = esm_pkg::XW;

    logic              en;
    logic              res_valid;
    esm_pkg::result_t  res;
    esm_pkg::cordic_t  front;
    esm_pkg::cordic_t  st [N+1];
    logic [N:0]        stv;

    assign en        = !res_valid || mat.ready;
    assign obj.ready = en;

    // fold angles into the right half turn and seed the CORDIC lanes
    always_comb
    begin
        logic [2:0][AB-1:0] ang;
        logic [31:0]        p;
        logic [31:0]        q;
        ang[0] = obj.angle_y[AB-1:0];
        ang[1] = obj.angle_x[AB-1:0];
        ang[2] = obj.angle_z[AB-1:0];
        front.valid = obj.valid && (obj.scale_x > 16'sd0);
        for (int k = 0; k < 3; k++)
        begin
            p = {ang[k], {(32-AB){1'b0}}};
            q = p + 32'h4000_0000;
            front.neg[k] = q[31];
            if (q[31])
            begin
                p = p ^ 32'h8000_0000;
            end
            front.z[k] = {{(XW-32){p[31]}}, p};
            front.x[k] = esm_pkg::CORDIC_ONE;
            front.y[k] = '0;
        end
        front.pos   = {obj.pos_z, obj.pos_y, obj.pos_x};
        front.scale = {obj.scale_z, obj.scale_y, obj.scale_x};
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st[0] <= '0;
        end
        else if (en)
        begin
            st[0] <= front;
        end
    end

    // row of CORDIC cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        esm_cordic_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .step   (esm_pkg::STEP_W'(i)),
            .st_in  (st[i]),
            .st_out (st[i+1])
        );
    end

    for (genvar i = 0; i <= N; i++)
    begin : g_valid
        assign stv[i] = st[i].valid;
    end

    esm_matrix_math u_math (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .st        (st[N]),
        .res_valid (res_valid),
        .res       (res)
    );

    assign mat.valid = res_valid;
    assign mat.m00   = res.m[0];
    assign mat.m01   = res.m[1];
    assign mat.m02   = res.m[2];
    assign mat.m10   = res.m[3];
    assign mat.m11   = res.m[4];
    assign mat.m12   = res.m[5];
    assign mat.m20   = res.m[6];
    assign mat.m21   = res.m[7];
    assign mat.m22   = res.m[8];
    assign mat.tx    = res.t[0];
    assign mat.ty    = res.t[1];
    assign mat.tz    = res.t[2];

    // drop objects with a non-positive x scale at the door
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        obj.valid && obj.ready && (obj.scale_x <= 16'sd0) |=> !stv[0])
        else $error("object with non-positive x scale entered the row");

    // a beat in the input stage moves to the first cell when the row advances
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        stv[0] && en |=> stv[1])
        else $error("beat lost between input stage and first cell");

    // a stalled row keeps its occupancy
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(stv) && res_valid)
        else $error("row changed while stalled");

endmodule
